[design/dht_pkg.sv]
// shared constants, codes and types for the double hash term table
package dht_pkg;

    localparam int CAPACITY_DEF    = 4096;
    localparam int VALUE_WIDTH_DEF = 64;

    localparam int SLOT_W  = 13;
    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 2;
    localparam int MODE_W  = 2;
    localparam int WORD_W  = 32;
    localparam int VALP_W  = 64;
    localparam int STAT_W  = 3;
    localparam int DIV_STEPS = 32;

    localparam logic [CIDX_W-1:0] CFG_BUCKETS   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 2'd1;

    localparam logic [CFG_W-1:0] BUCKETS_RST   = 13'd3;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 13'd2;
    localparam int MIN_BUCKETS = 3;

    localparam logic [1:0] MODE_LOOKUP   = 2'd0;
    localparam logic [1:0] MODE_INSERT   = 2'd1;
    localparam logic [1:0] MODE_INS_VAL  = 2'd2;
    localparam logic [1:0] MODE_DELETE   = 2'd3;

    localparam logic [1:0] FLAG_LIVE  = 2'b00;
    localparam logic [1:0] FLAG_DEL   = 2'b01;
    localparam logic [1:0] FLAG_EMPTY = 2'b10;

    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd0;
    localparam logic [STAT_W-1:0] ST_INS_EMPTY = 3'd1;
    localparam logic [STAT_W-1:0] ST_INS_DEL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_DEL_RD,
        S_DEL_CHK,
        S_DONE
    } t_state;

endpackage

[design/dht_ram.sv]
// generic simple dual port ram with registered read
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/double_hash_term_table.sv]
// open addressing term table, double hashing, flags with keys in one ram, values in another
// delete reads and checks the addressed slot; lookup and insert first run the
// bit-serial remainder unit (hash mod nb, mod nb-1), then make one
// read-and-check pass over the slot rams per probed slot
// one request at a time: input stalls until the result is handed on, longer on output stall
// reset: a clearing pass empties every slot and zeroes values
module double_hash_term_table #(
    parameter int CAPACITY    = dht_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dht_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dht_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [dht_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dht_pkg::MODE_W-1:0]    i_mode,
    input  logic [dht_pkg::WORD_W-1:0]    i_key_word,
    input  logic [dht_pkg::WORD_W-1:0]    i_key_field,
    input  logic [dht_pkg::SLOT_W-1:0]    i_slot_in,
    input  logic [dht_pkg::VALP_W-1:0]    i_value_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dht_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [dht_pkg::STAT_W-1:0]    o_status,
    output logic [dht_pkg::VALP_W-1:0]    o_value_out,
    output logic [dht_pkg::SLOT_W-1:0]    o_live_count,
    output logic [dht_pkg::SLOT_W-1:0]    o_occupied_count,
    output logic                          o_needs_grow
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = 2 * dht_pkg::WORD_W;
    localparam logic [IW-1:0] LAST_ADDR = IW'(CAPACITY - 1);

    dht_pkg::t_state r_state, n_state;

    logic [dht_pkg::CFG_W-1:0] r_buckets, r_threshold;

    logic [dht_pkg::MODE_W-1:0] r_mode;
    logic [KW-1:0]              r_key;
    logic [VALUE_WIDTH-1:0]     r_val;
    logic [dht_pkg::SLOT_W-1:0] r_sin;
    logic [dht_pkg::WORD_W-1:0] r_hash;
    logic [CW-1:0]              r_rem1, r_rem2;
    logic [4:0]                 r_cnt;
    logic [IW-1:0]              r_idx, r_inc, r_last, r_site;
    logic                       r_site_ok;
    logic [IW-1:0]              r_clr;
    logic [CW-1:0]              r_live, r_used;
    logic [CW-1:0]              r_res_slot;
    logic [dht_pkg::STAT_W-1:0] r_res_st;
    logic [VALUE_WIDTH-1:0]     r_res_val;

    logic                       r_out_valid;
    logic [dht_pkg::SLOT_W-1:0] r_out_slot;
    logic [dht_pkg::STAT_W-1:0] r_out_st;
    logic [dht_pkg::VALP_W-1:0] r_out_val;
    logic [dht_pkg::SLOT_W-1:0] r_out_live, r_out_used;
    logic                       r_out_grow;

    // effective bucket count
    logic [31:0] bk32, nb32;
    logic [CW-1:0] nb, nbm1;

    always_comb begin
        bk32 = 32'(r_buckets);
        if (bk32 < 32'(dht_pkg::MIN_BUCKETS)) begin
            nb32 = 32'(dht_pkg::MIN_BUCKETS);
        end else if (bk32 > 32'(CAPACITY)) begin
            nb32 = 32'(CAPACITY);
        end else begin
            nb32 = bk32;
        end
        nb   = CW'(nb32);
        nbm1 = nb - CW'(1);
    end

    // bit-serial remainder step
    logic [CW:0]   t1, t2;
    logic [CW-1:0] rem1_n, rem2_n;

    always_comb begin
        t1 = {r_rem1, r_hash[dht_pkg::WORD_W-1]};
        t2 = {r_rem2, r_hash[dht_pkg::WORD_W-1]};
        rem1_n = (t1 >= {1'b0, nb})   ? CW'(t1 - {1'b0, nb})   : CW'(t1);
        rem2_n = (t2 >= {1'b0, nbm1}) ? CW'(t2 - {1'b0, nbm1}) : CW'(t2);
    end

    // memories: flags and key of a slot share one word
    logic          slot_we, val_we;
    logic [IW-1:0] waddr, raddr;
    logic [1:0]    flg_wdata, flg_rdata;
    logic [KW-1:0] key_wdata, key_rdata;
    logic [KW+1:0] slot_wdata, slot_rdata;
    logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;

    assign slot_wdata = {flg_wdata, key_wdata};
    assign flg_rdata  = slot_rdata[KW+1:KW];
    assign key_rdata  = slot_rdata[KW-1:0];

    dht_ram #(.WIDTH(KW + 2), .DEPTH(CAPACITY)) u_slots (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(waddr), .i_wdata(slot_wdata),
        .i_raddr(raddr), .o_rdata(slot_rdata)
    );

    dht_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_values (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(waddr), .i_wdata(val_wdata),
        .i_raddr(raddr), .o_rdata(val_rdata)
    );

    // probe decisions
    logic          in_acc, out_free;
    logic          f_empty, f_del, f_live, f_match;
    logic [IW:0]   step_sum, nb_ext;
    logic [IW-1:0] idx_next, site_n;
    logic          site_ok_n;
    logic          probe_end, do_write, inc_live, inc_used, dec_live;
    logic [CW-1:0] res_slot;
    logic [dht_pkg::STAT_W-1:0] res_st;
    logic [VALUE_WIDTH-1:0] res_val;
    logic [IW-1:0] x_addr;
    logic          sin_ok;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        f_empty = flg_rdata == dht_pkg::FLAG_EMPTY;
        f_del   = flg_rdata == dht_pkg::FLAG_DEL;
        f_live  = flg_rdata == dht_pkg::FLAG_LIVE;
        f_match = f_live && (key_rdata == r_key);
        nb_ext   = (IW+1)'(nb);
        step_sum = {1'b0, r_idx} + {1'b0, r_inc};
        idx_next = (step_sum >= nb_ext) ? IW'(step_sum - nb_ext) : IW'(step_sum);
        site_n    = f_del ? r_idx : r_site;
        site_ok_n = f_del || r_site_ok;
        sin_ok = 32'(r_sin) < nb32;
    end

    always_comb begin
        probe_end = 1'b0;
        do_write  = 1'b0;
        inc_live  = 1'b0;
        inc_used  = 1'b0;
        dec_live  = 1'b0;
        res_slot  = nb;
        res_st    = dht_pkg::ST_NOTFOUND;
        res_val   = '0;
        x_addr    = r_idx;
        slot_we   = 1'b0;
        val_we    = 1'b0;
        flg_wdata = dht_pkg::FLAG_LIVE;
        key_wdata = r_key;
        val_wdata = r_val;
        waddr     = r_idx;
        raddr     = r_idx;
        case (r_state)
            dht_pkg::S_CLEAR: begin
                slot_we   = 1'b1;
                val_we    = 1'b1;
                flg_wdata = dht_pkg::FLAG_EMPTY;
                key_wdata = '0;
                val_wdata = '0;
                waddr     = r_clr;
            end
            dht_pkg::S_DEL_RD: begin
                raddr = IW'(r_sin);
            end
            dht_pkg::S_DEL_CHK: begin
                waddr     = IW'(r_sin);
                key_wdata = key_rdata;
                if (sin_ok && f_live) begin
                    slot_we   = 1'b1;
                    flg_wdata = dht_pkg::FLAG_DEL;
                    dec_live  = 1'b1;
                    res_slot  = CW'(r_sin);
                    res_st    = dht_pkg::ST_PRESENT;
                end
            end
            dht_pkg::S_PROBE_CHK: begin
                if (r_mode == dht_pkg::MODE_LOOKUP) begin
                    if (f_empty) begin
                        probe_end = 1'b1;
                    end else if (f_match) begin
                        probe_end = 1'b1;
                        res_slot  = CW'(r_idx);
                        res_st    = dht_pkg::ST_PRESENT;
                        res_val   = val_rdata;
                    end else if (idx_next == r_last) begin
                        probe_end = 1'b1;
                    end
                end else begin
                    if (f_empty) begin
                        probe_end = 1'b1;
                        do_write  = 1'b1;
                        if (r_site_ok) begin
                            x_addr = r_site;
                            res_st = dht_pkg::ST_INS_DEL;
                        end else begin
                            x_addr   = r_idx;
                            res_st   = dht_pkg::ST_INS_EMPTY;
                            inc_used = 1'b1;
                        end
                        inc_live = 1'b1;
                    end else if (f_match) begin
                        probe_end = 1'b1;
                        x_addr    = r_idx;
                        res_st    = dht_pkg::ST_PRESENT;
                    end else if (idx_next == r_last) begin
                        probe_end = 1'b1;
                        if (site_ok_n) begin
                            do_write = 1'b1;
                            inc_live = 1'b1;
                            x_addr   = site_n;
                            res_st   = dht_pkg::ST_INS_DEL;
                        end else begin
                            res_st = dht_pkg::ST_FULL;
                        end
                    end
                    if (probe_end && res_st != dht_pkg::ST_FULL) begin
                        res_slot = CW'(x_addr);
                    end
                    waddr   = x_addr;
                    slot_we = do_write;
                    val_we  = probe_end && (r_mode == dht_pkg::MODE_INS_VAL)
                              && (res_st != dht_pkg::ST_FULL);
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dht_pkg::S_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    n_state = dht_pkg::S_IDLE;
                end
            end
            dht_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_mode == dht_pkg::MODE_DELETE) ? dht_pkg::S_DEL_RD
                                                               : dht_pkg::S_DIV;
                end
            end
            dht_pkg::S_DIV: begin
                if (r_cnt == 5'(dht_pkg::DIV_STEPS - 1)) begin
                    n_state = dht_pkg::S_PROBE_RD;
                end
            end
            dht_pkg::S_PROBE_RD:  n_state = dht_pkg::S_PROBE_CHK;
            dht_pkg::S_PROBE_CHK: n_state = probe_end ? dht_pkg::S_DONE
                                                      : dht_pkg::S_PROBE_RD;
            dht_pkg::S_DEL_RD:    n_state = dht_pkg::S_DEL_CHK;
            dht_pkg::S_DEL_CHK:   n_state = dht_pkg::S_DONE;
            dht_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = dht_pkg::S_IDLE;
                end
            end
            default: n_state = dht_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dht_pkg::S_CLEAR;
            r_buckets   <= dht_pkg::BUCKETS_RST;
            r_threshold <= dht_pkg::THRESHOLD_RST;
            r_clr       <= '0;
            r_live      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == dht_pkg::CFG_BUCKETS) begin
                    r_buckets <= i_cfg_data;
                end else if (i_cfg_index == dht_pkg::CFG_THRESHOLD) begin
                    r_threshold <= i_cfg_data;
                end
            end
            if (r_state == dht_pkg::S_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (inc_live) begin
                r_live <= r_live + CW'(1);
            end else if (dec_live) begin
                r_live <= r_live - CW'(1);
            end
            if (inc_used) begin
                r_used <= r_used + CW'(1);
            end
            if (r_state == dht_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_key  <= {i_key_word, i_key_field};
            r_val  <= VALUE_WIDTH'(i_value_in);
            r_sin  <= i_slot_in;
            r_hash <= i_key_word ^ i_key_field;
            r_rem1 <= '0;
            r_rem2 <= '0;
            r_cnt  <= '0;
        end
        if (r_state == dht_pkg::S_DIV) begin
            r_rem1 <= rem1_n;
            r_rem2 <= rem2_n;
            r_hash <= {r_hash[dht_pkg::WORD_W-2:0], 1'b0};
            r_cnt  <= r_cnt + 5'd1;
            if (r_cnt == 5'(dht_pkg::DIV_STEPS - 1)) begin
                r_idx     <= IW'(rem1_n);
                r_last    <= IW'(rem1_n);
                r_inc     <= IW'(rem2_n) + IW'(1);
                r_site_ok <= 1'b0;
            end
        end
        if (r_state == dht_pkg::S_PROBE_CHK) begin
            r_idx     <= idx_next;
            r_site    <= site_n;
            r_site_ok <= site_ok_n;
        end
        if ((r_state == dht_pkg::S_PROBE_CHK && probe_end)
            || r_state == dht_pkg::S_DEL_CHK) begin
            r_res_slot <= res_slot;
            r_res_st   <= res_st;
            r_res_val  <= res_val;
        end
        if (r_state == dht_pkg::S_DONE && out_free) begin
            r_out_slot <= dht_pkg::SLOT_W'(r_res_slot);
            r_out_st   <= r_res_st;
            r_out_val  <= dht_pkg::VALP_W'(r_res_val);
            r_out_live <= dht_pkg::SLOT_W'(r_live);
            r_out_used <= dht_pkg::SLOT_W'(r_used);
            r_out_grow <= 32'(r_used) >= 32'(r_threshold);
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = r_state != dht_pkg::S_IDLE;
    assign o_out_valid      = r_out_valid;
    assign o_slot_out       = r_out_slot;
    assign o_status         = r_out_st;
    assign o_value_out      = r_out_val;
    assign o_live_count     = r_out_live;
    assign o_occupied_count = r_out_used;
    assign o_needs_grow     = r_out_grow;

endmodule

[verif/tb_double_hash_term_table.sv]
// self-checking testbench for the double hash term table, with a built-in table predictor
module tb_double_hash_term_table;
    import dht_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int CYCLE_MAX  = 3000000;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] kw;
        logic [WORD_W-1:0] kf;
        logic [SLOT_W-1:0] slot;
        logic [VALP_W-1:0] val;
    } t_request;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [STAT_W-1:0] status;
        logic [VALP_W-1:0] val;
        logic [SLOT_W-1:0] live;
        logic [SLOT_W-1:0] occupied;
        logic              grow;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CIDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [MODE_W-1:0]    i_mode = '0;
    logic [WORD_W-1:0]    i_key_word = '0;
    logic [WORD_W-1:0]    i_key_field = '0;
    logic [SLOT_W-1:0]    i_slot_in = '0;
    logic [VALP_W-1:0]    i_value_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [SLOT_W-1:0]    o_slot_out;
    logic [STAT_W-1:0]    o_status;
    logic [VALP_W-1:0]    o_value_out;
    logic [SLOT_W-1:0]    o_live_count;
    logic [SLOT_W-1:0]    o_occupied_count;
    logic                 o_needs_grow;

    double_hash_term_table u_top (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the table
    logic [1:0]        tbl_flags [CAP];
    logic [63:0]       tbl_keys  [CAP];
    logic [63:0]       tbl_vals  [CAP];
    int unsigned       tbl_live;
    int unsigned       tbl_used;
    logic [CFG_W-1:0]  buckets_reg = BUCKETS_RST;
    logic [CFG_W-1:0]  thresh_reg  = THRESHOLD_RST;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    int       errors = 0;
    int       cycles = 0;

    initial begin
        for (int k = 0; k < CAP; k++) begin
            tbl_flags[k] = FLAG_EMPTY;
            tbl_keys[k]  = '0;
            tbl_vals[k]  = '0;
        end
        tbl_live = 0;
        tbl_used = 0;
    end

    function automatic int unsigned eff_buckets();
        int unsigned n;
        n = 32'(buckets_reg);
        if (n < MIN_BUCKETS) n = MIN_BUCKETS;
        if (n > CAP) n = CAP;
        return n;
    endfunction

    // apply one request to the predicted table and return its answer
    function automatic t_answer table_apply(t_request rq);
        int unsigned nb, hash, i, inc, last, x, site;
        logic [63:0] key;
        bit          full;
        t_answer     a;
        nb = eff_buckets();
        key = {rq.kw, rq.kf};
        hash = rq.kw ^ rq.kf;
        a.slot = nb[SLOT_W-1:0];
        a.status = ST_NOTFOUND;
        a.val = '0;
        case (rq.mode)
            MODE_LOOKUP: begin
                i = hash % nb;
                inc = 1 + hash % (nb - 1);
                last = i;
                while (tbl_flags[i] != FLAG_EMPTY &&
                       (tbl_flags[i] == FLAG_DEL || tbl_keys[i] != key)) begin
                    i = (i + inc >= nb) ? i + inc - nb : i + inc;
                    if (i == last) begin
                        i = nb;
                        break;
                    end
                end
                if (i != nb && tbl_flags[i] == FLAG_LIVE) begin
                    a.slot = i[SLOT_W-1:0];
                    a.status = ST_PRESENT;
                    a.val = tbl_vals[i];
                end
            end
            MODE_DELETE: begin
                if (rq.slot < nb && tbl_flags[rq.slot] == FLAG_LIVE) begin
                    tbl_flags[rq.slot] = FLAG_DEL;
                    tbl_live--;
                    a.slot = rq.slot;
                    a.status = ST_PRESENT;
                end
            end
            default: begin
                full = 0;
                i = hash % nb;
                x = nb;
                site = nb;
                if (tbl_flags[i] == FLAG_EMPTY) begin
                    x = i;
                end else begin
                    inc = 1 + hash % (nb - 1);
                    last = i;
                    while (tbl_flags[i] != FLAG_EMPTY &&
                           (tbl_flags[i] == FLAG_DEL || tbl_keys[i] != key)) begin
                        if (tbl_flags[i] == FLAG_DEL) site = i;
                        i = (i + inc >= nb) ? i + inc - nb : i + inc;
                        if (i == last) begin
                            x = site;
                            break;
                        end
                    end
                    if (x == nb && i == last && tbl_keys[i] != key) full = 1;
                    else if (x == nb)
                        x = (tbl_flags[i] == FLAG_EMPTY && site != nb) ? site : i;
                end
                if (full) begin
                    a.status = ST_FULL;
                end else begin
                    if (tbl_flags[x] == FLAG_EMPTY) begin
                        tbl_keys[x] = key;
                        tbl_flags[x] = FLAG_LIVE;
                        tbl_live++;
                        tbl_used++;
                        a.status = ST_INS_EMPTY;
                    end else if (tbl_flags[x] == FLAG_DEL) begin
                        tbl_keys[x] = key;
                        tbl_flags[x] = FLAG_LIVE;
                        tbl_live++;
                        a.status = ST_INS_DEL;
                    end else begin
                        a.status = ST_PRESENT;
                    end
                    a.slot = x[SLOT_W-1:0];
                    if (rq.mode == MODE_INS_VAL) tbl_vals[x] = rq.val;
                end
            end
        endcase
        a.live = tbl_live[SLOT_W-1:0];
        a.occupied = tbl_used[SLOT_W-1:0];
        a.grow = (tbl_used >= 32'(thresh_reg));
        return a;
    endfunction

    // request driver: bursts with random gaps
    t_request cur_req;
    int       burst_left = 1;
    int       gap_left = 0;
    always @(posedge i_clk) begin
        bit hold;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                expected_answers.push_back(table_apply(cur_req));
            hold = i_in_valid && o_in_stall;
            if (!hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    hold = 1;
                    i_mode <= cur_req.mode;
                    i_key_word <= cur_req.kw;
                    i_key_field <= cur_req.kf;
                    i_slot_in <= cur_req.slot;
                    i_value_in <= cur_req.val;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
                    end
                end
            end
            i_in_valid <= hold;
        end
    end

    // result stall pattern, with stretches of no stall
    int stall_pct = 0;
    int stall_run = 0;
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 25;
                default: stall_pct = 75;
            endcase
            stall_run = $urandom_range(50, 300);
        end
        stall_run--;
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        t_answer e;
        if (o_out_valid && !i_out_stall) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result slot %0d status %0d", $time,
                         o_slot_out, o_status);
                errors++;
            end else begin
                e = expected_answers.pop_front();
                if (o_slot_out !== e.slot) begin
                    $display("%0t: slot exp %0d got %0d", $time, e.slot, o_slot_out);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_value_out !== e.val) begin
                    $display("%0t: value exp %h got %h", $time, e.val, o_value_out);
                    errors++;
                end
                if (o_live_count !== e.live) begin
                    $display("%0t: live exp %0d got %0d", $time, e.live, o_live_count);
                    errors++;
                end
                if (o_occupied_count !== e.occupied) begin
                    $display("%0t: occupied exp %0d got %0d", $time, e.occupied,
                             o_occupied_count);
                    errors++;
                end
                if (o_needs_grow !== e.grow) begin
                    $display("%0t: grow exp %0b got %0b", $time, e.grow, o_needs_grow);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("FAIL double_hash_term_table");
            $finish;
        end
    end

    task automatic push_req(logic [MODE_W-1:0] m, logic [31:0] kw, logic [31:0] kf,
                            logic [SLOT_W-1:0] s, logic [63:0] v);
        t_request rq;
        rq.mode = m;
        rq.kw = kw;
        rq.kf = kf;
        rq.slot = s;
        rq.val = v;
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_in_valid || expected_answers.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_BUCKETS) buckets_reg = data;
        else if (idx == CFG_THRESHOLD) thresh_reg = data;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        logic [63:0] pool[$];
        int unsigned nb, psize, r;
        logic [63:0] k;
        nb = eff_buckets();
        psize = (nb < 40) ? nb + 3 : 48;
        for (int p = 0; p < psize; p++) pool.push_back({$urandom, $urandom});
        for (int n = 0; n < count; n++) begin
            k = pool[$urandom_range(0, psize - 1)];
            r = $urandom_range(0, 99);
            if (r < 30)
                push_req(MODE_LOOKUP, k[63:32], k[31:0], SLOT_W'($urandom),
                         {$urandom, $urandom});
            else if (r < 60)
                push_req($urandom_range(0, 1) ? MODE_INSERT : MODE_INS_VAL, k[63:32],
                         k[31:0], SLOT_W'($urandom), {$urandom, $urandom});
            else if (r < 80)
                push_req(MODE_DELETE, $urandom, $urandom,
                         SLOT_W'($urandom_range(0, nb + 1)), {$urandom, $urandom});
            else if (r < 88)
                push_req(MODE_DELETE, $urandom, $urandom, SLOT_W'($urandom),
                         {$urandom, $urandom});
            else
                push_req(MODE_W'($urandom_range(0, 3)), $urandom, $urandom,
                         SLOT_W'($urandom), {$urandom, $urandom});
            // one full drain mid-phase
            if (n == count / 2) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: three buckets, fill, full, tombstone reuse, overwrite
        push_req(MODE_INS_VAL, 32'h0, 32'h0, 13'd0, {64{1'b1}});
        push_req(MODE_INSERT, 32'hffffffff, 32'hffffffff, 13'h1fff, 64'h0);
        push_req(MODE_INSERT, 32'h12345678, 32'h0000000f, 13'd0, 64'h0);
        push_req(MODE_INSERT, 32'h0badcafe, 32'h00000003, 13'd0, 64'h0);
        push_req(MODE_LOOKUP, 32'h0, 32'h0, 13'd0, 64'h0);
        push_req(MODE_LOOKUP, 32'hffffffff, 32'hffffffff, 13'd0, 64'h0);
        push_req(MODE_LOOKUP, 32'h12345678, 32'h0000000f, 13'd0, 64'h0);
        push_req(MODE_LOOKUP, 32'h0badcafe, 32'h00000003, 13'd0, 64'h0);
        push_req(MODE_DELETE, 32'h0, 32'h0, 13'd1, 64'h0);
        push_req(MODE_DELETE, 32'h0, 32'h0, 13'd1, 64'h0);
        push_req(MODE_DELETE, 32'h0, 32'h0, 13'h1fff, 64'h0);
        push_req(MODE_DELETE, 32'h0, 32'h0, 13'd3, 64'h0);
        push_req(MODE_LOOKUP, 32'hffffffff, 32'hffffffff, 13'd0, 64'h0);
        push_req(MODE_INS_VAL, 32'h0badcafe, 32'h00000003, 13'd0, 64'h1);
        push_req(MODE_INS_VAL, 32'h0, 32'h0, 13'd0, 64'h5555555555555555);
        push_req(MODE_LOOKUP, 32'h0, 32'h0, 13'd0, 64'h0);
        push_req(MODE_INSERT, 32'hffffffff, 32'hffffffff, 13'd0, 64'h0);
        push_req(MODE_LOOKUP, 32'h0badcafe, 32'h00000003, 13'd0, 64'h0);
        wait_drained();
        random_phase(200);

        write_reg(CFG_BUCKETS, 13'd7);
        write_reg(CFG_THRESHOLD, 13'd3);
        random_phase(300);
        write_reg(CFG_BUCKETS, 13'd13);
        write_reg(CFG_THRESHOLD, 13'h1fff);
        random_phase(250);
        // below range saturates to three buckets, zero threshold always grows
        write_reg(CFG_BUCKETS, 13'd0);
        write_reg(CFG_THRESHOLD, 13'd0);
        random_phase(200);
        write_reg(CFG_BUCKETS, 13'd31);
        write_reg(CFG_THRESHOLD, 13'd20);
        random_phase(300);
        // above capacity saturates to the full table
        write_reg(CFG_BUCKETS, 13'h1fff);
        write_reg(CFG_THRESHOLD, 13'd1);
        random_phase(150);
        write_reg(CFG_BUCKETS, 13'd5);
        write_reg(CFG_THRESHOLD, 13'd4);
        random_phase(150);

        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("PASS double_hash_term_table");
        end else begin
            $display("FAIL double_hash_term_table");
        end
        $finish;
    end

endmodule
